@@ rtl/rbsc_pkg.sv @@
// Package for the ray/box slab clipper: beat payload types, pipeline stage
// types, register codes and pipeline sizing constants.
// No dependencies.
package rbsc_pkg;

   // Value width (signed Q16.16) and the number of restoring division cells.
   localparam int VAL_W   = 32;
   localparam int NCELL   = 32;
   localparam int NAXIS   = 3;
   // Two set-up stages, the cell row, one sign/saturate stage, one stage per axis.
   localparam int NSTAGE  = 2 + NCELL + 1 + NAXIS;
   localparam int ADDR_W  = 5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MIN_Y = 3'd1;
   localparam logic [2:0] REG_MIN_Z = 3'd2;
   localparam logic [2:0] REG_MAX_X = 3'd3;
   localparam logic [2:0] REG_MAX_Y = 3'd4;
   localparam logic [2:0] REG_MAX_Z = 3'd5;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] direction_x;
      logic signed [31:0] direction_y;
      logic signed [31:0] direction_z;
      logic signed [31:0] near_in;
      logic signed [31:0] far_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] near_out;
      logic signed [31:0] far_out;
      logic               interval_empty;
   } rsp_type;

   // Box corners, indexed by axis.
   typedef struct packed {
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
   } box_type;

   // First set-up stage: exact side minus origin differences.
   // Lanes 0..2 are the entry sides of x, y, z; lanes 3..5 the exit sides.
   typedef struct packed {
      logic [5:0][32:0] diff;
      logic [2:0][31:0] dir;
      logic [31:0]      near;
      logic [31:0]      far;
   } prep_type;

   // One division lane as it travels down the cell row.
   typedef struct packed {
      logic [31:0] rem;   // partial remainder, below the divisor unless ovf is set
      logic [31:0] work;  // dividend bits shift out at the top, quotient bits in at the bottom
      logic [31:0] dvs;   // divisor magnitude
      logic        neg;   // quotient is negative
      logic        ovf;   // quotient magnitude is 2^32 or more
   } lane_type;

   typedef struct packed {
      lane_type [5:0] lane;
      logic [2:0]     skip;
      logic [31:0]    near;
      logic [31:0]    far;
   } step_type;

   // Clip stage: distances still to be applied sit at index 0 and shift down.
   typedef struct packed {
      logic [2:0][31:0] ent;
      logic [2:0][31:0] ext;
      logic [2:0]       skip;
      logic [31:0]      near;
      logic [31:0]      far;
      logic             done;
   } clip_type;

endpackage

@@ rtl/ray_box_slab_clip.sv @@
// Ray/box slab clipper, top level. Beats pass through two set-up stages, 32
// division cells, one saturation stage and one clipping stage per axis.
// Throughput is one beat per cycle while rsp_ready is high; each stage moves
// on when it is empty or its successor moves, so bubbles close up.
// Synchronous active-high reset empties the pipeline and clears the box to zero.
module ray_box_slab_clip (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rbsc_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rbsc_pkg::rsp_type         rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [rbsc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import rbsc_pkg::*;

   box_type            box_ff;
   logic [NSTAGE-1:0]  valid_ff;
   logic [NSTAGE-1:0]  valid_in;
   logic [NSTAGE-1:0]  adv;
   logic [2:0]         reg_idx;
   step_type           chain [NCELL+1];
   clip_type           clip_chain [NAXIS+1];

   // Configuration registers.
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_MIN_X: box_ff.lo[0] <= pwdata;
            REG_MIN_Y: box_ff.lo[1] <= pwdata;
            REG_MIN_Z: box_ff.lo[2] <= pwdata;
            REG_MAX_X: box_ff.hi[0] <= pwdata;
            REG_MAX_Y: box_ff.hi[1] <= pwdata;
            REG_MAX_Z: box_ff.hi[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_X: prdata = box_ff.lo[0];
         REG_MIN_Y: prdata = box_ff.lo[1];
         REG_MIN_Z: prdata = box_ff.lo[2];
         REG_MAX_X: prdata = box_ff.hi[0];
         REG_MAX_Y: prdata = box_ff.hi[1];
         REG_MAX_Z: prdata = box_ff.hi[2];
         default:   prdata = '0;
      endcase
   end

   // Stage advance: a stage loads when it is empty or its contents move on.
   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in = {valid_ff[NSTAGE-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = adv[0];

   // Datapath.
   rbsc_prep u_prep (
      .clock    (clock),
      .en_a     (adv[0]),
      .en_b     (adv[1]),
      .req_in   (req_data),
      .box      (box_ff),
      .step_out (chain[0])
   );

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rbsc_div_cell u_cell (
         .clock    (clock),
         .en       (adv[2 + i]),
         .step_in  (chain[i]),
         .step_out (chain[i+1])
      );
   end

   rbsc_post u_post (
      .clock    (clock),
      .en       (adv[2 + NCELL]),
      .step_in  (chain[NCELL]),
      .clip_out (clip_chain[0])
   );

   for (genvar a = 0; a < NAXIS; a++) begin : g_axis
      rbsc_clip u_clip (
         .clock    (clock),
         .en       (adv[3 + NCELL + a]),
         .clip_in  (clip_chain[a]),
         .clip_out (clip_chain[a+1])
      );
   end

   // Response beat.
   assign rsp_valid               = valid_ff[NSTAGE-1];
   assign rsp_data.near_out       = clip_chain[NAXIS].near;
   assign rsp_data.far_out        = clip_chain[NAXIS].far;
   assign rsp_data.interval_empty =
      $signed(clip_chain[NAXIS].near) > $signed(clip_chain[NAXIS].far);

`ifndef SYNTHESIS
   // The pipeline is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // Requests are refused only when every stage is full.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("request refused with a free stage");

   // A stalled response is kept until taken.
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled response lost");

   // A stage that is full and told to hold stays full.
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !adv[0]) |=> valid_ff[0])
      else $error("held stage emptied");
`endif

endmodule

@@ rtl/rbsc_prep.sv @@
// Two set-up stages: picks the box sides, forms the differences, then the
// magnitudes, signs and overflow flags for six divisions. Uses rbsc_pkg.
module rbsc_prep (
   input  logic              clock,
   input  logic              en_a,
   input  logic              en_b,
   input  rbsc_pkg::req_type req_in,
   input  rbsc_pkg::box_type box,
   output rbsc_pkg::step_type step_out
);
   import rbsc_pkg::*;

   prep_type a_ff, a_in;
   step_type b_ff, b_in;

   // Stage A: choose entry and exit sides by the direction's sign.
   always_comb begin
      logic [2:0][31:0] org;
      logic [2:0][31:0] dir;
      logic [31:0]      ent_side;
      logic [31:0]      ext_side;
      org = {req_in.origin_z, req_in.origin_y, req_in.origin_x};
      dir = {req_in.direction_z, req_in.direction_y, req_in.direction_x};
      a_in = '0;
      for (int ax = 0; ax < NAXIS; ax++) begin
         ent_side = dir[ax][31] ? box.hi[ax] : box.lo[ax];
         ext_side = dir[ax][31] ? box.lo[ax] : box.hi[ax];
         a_in.diff[ax]     = {ent_side[31], ent_side} - {org[ax][31], org[ax]};
         a_in.diff[ax + 3] = {ext_side[31], ext_side} - {org[ax][31], org[ax]};
      end
      a_in.dir  = dir;
      a_in.near = req_in.near_in;
      a_in.far  = req_in.far_in;
   end

   // Stage B: magnitudes of the scaled numerator and of the divisor.
   always_comb begin
      logic [48:0] num;
      logic [48:0] absnum;
      logic [31:0] absdir;
      logic [31:0] dvd_hi;
      b_in = '0;
      for (int s = 0; s < 2; s++) begin
         for (int ax = 0; ax < NAXIS; ax++) begin
            num    = {a_ff.diff[s*3 + ax], 16'h0000};
            absnum = a_ff.diff[s*3 + ax][32] ? (~num + 49'd1) : num;
            absdir = a_ff.dir[ax][31] ? (~a_ff.dir[ax] + 32'd1) : a_ff.dir[ax];
            dvd_hi = {15'h0000, absnum[48:32]};
            b_in.lane[s*3 + ax].rem  = dvd_hi;
            b_in.lane[s*3 + ax].work = absnum[31:0];
            b_in.lane[s*3 + ax].dvs  = absdir;
            b_in.lane[s*3 + ax].neg  = a_ff.diff[s*3 + ax][32] ^ a_ff.dir[ax][31];
            b_in.lane[s*3 + ax].ovf  = (dvd_hi >= absdir);
         end
      end
      for (int ax = 0; ax < NAXIS; ax++) begin
         b_in.skip[ax] = (a_ff.dir[ax] == '0);
      end
      b_in.near = a_ff.near;
      b_in.far  = a_ff.far;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ff <= a_in;
      end
      if (en_b) begin
         b_ff <= b_in;
      end
   end

   assign step_out = b_ff;

endmodule

@@ rtl/rbsc_div_cell.sv @@
// One restoring division cell: produces one quotient bit for each of the six
// lanes and hands the rest on. Uses rbsc_pkg.
module rbsc_div_cell (
   input  logic               clock,
   input  logic               en,
   input  rbsc_pkg::step_type step_in,
   output rbsc_pkg::step_type step_out
);
   import rbsc_pkg::*;

   step_type step_ff, step_in_next;

   // Shift in the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      logic [32:0] r2;
      logic        ge;
      step_in_next = step_in;
      for (int l = 0; l < 6; l++) begin
         r2 = {step_in.lane[l].rem, step_in.lane[l].work[31]};
         ge = (r2 >= {1'b0, step_in.lane[l].dvs});
         step_in_next.lane[l].rem  = ge ? 32'(r2 - {1'b0, step_in.lane[l].dvs}) : r2[31:0];
         step_in_next.lane[l].work = {step_in.lane[l].work[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in_next;
      end
   end

   assign step_out = step_ff;

endmodule

@@ rtl/rbsc_post.sv @@
// Sign and saturation stage: turns quotient magnitudes into signed Q16.16
// distances clamped to 32 bits. Uses rbsc_pkg.
module rbsc_post (
   input  logic               clock,
   input  logic               en,
   input  rbsc_pkg::step_type step_in,
   output rbsc_pkg::clip_type clip_out
);
   import rbsc_pkg::*;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   clip_type clip_ff, clip_in;

   // Clamp, then apply the sign.
   always_comb begin
      logic [5:0][31:0] lane_t;
      logic [31:0]      mag;
      for (int l = 0; l < 6; l++) begin
         mag = step_in.lane[l].work;
         if (step_in.lane[l].ovf) begin
            lane_t[l] = step_in.lane[l].neg ? SAT_NEG : SAT_POS;
         end else if (!step_in.lane[l].neg) begin
            lane_t[l] = mag[31] ? SAT_POS : mag;
         end else begin
            lane_t[l] = (mag > SAT_NEG) ? SAT_NEG : (~mag + 32'd1);
         end
      end
      clip_in.ent  = lane_t[2:0];
      clip_in.ext  = lane_t[5:3];
      clip_in.skip = step_in.skip;
      clip_in.near = step_in.near;
      clip_in.far  = step_in.far;
      clip_in.done = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         clip_ff <= clip_in;
      end
   end

   assign clip_out = clip_ff;

endmodule

@@ rtl/rbsc_clip.sv @@
// One axis of interval clipping: applies the distances at index 0, marks an
// empty interval as finished and shifts the next axis down. Uses rbsc_pkg.
module rbsc_clip (
   input  logic               clock,
   input  logic               en,
   input  rbsc_pkg::clip_type clip_in,
   output rbsc_pkg::clip_type clip_out
);
   import rbsc_pkg::*;

   clip_type clip_ff, clip_next;

   // Raise the start, lower the end, unless the axis is skipped or the ray has left.
   // Only an axis that is actually clipped can end the walk; a skipped axis never
   // does, even when the incoming interval is already inverted.
   always_comb begin
      logic [31:0] t0;
      logic [31:0] t1;
      t0 = clip_in.near;
      t1 = clip_in.far;
      if (!clip_in.done && !clip_in.skip[0]) begin
         if ($signed(clip_in.ent[0]) > $signed(t0)) begin
            t0 = clip_in.ent[0];
         end
         if ($signed(clip_in.ext[0]) < $signed(t1)) begin
            t1 = clip_in.ext[0];
         end
      end
      clip_next.near = t0;
      clip_next.far  = t1;
      clip_next.done = clip_in.done || (!clip_in.skip[0] && ($signed(t0) > $signed(t1)));
      clip_next.ent  = {32'h0, clip_in.ent[2:1]};
      clip_next.ext  = {32'h0, clip_in.ext[2:1]};
      clip_next.skip = {1'b1, clip_in.skip[2:1]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         clip_ff <= clip_next;
      end
   end

   assign clip_out = clip_ff;

endmodule

@@ sim/slab_clip_checker.sv @@
// Checker for the ray/box slab clipper: watches the request, response and
// register ports, predicts each response and compares it field by field.
// Depends on rbsc_pkg.
module slab_clip_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  rbsc_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  rbsc_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rbsc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output int                          error_count,
   output int                          pending
);
   import rbsc_pkg::*;

   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];
   rsp_type clipped_q [$];

   assign pending = clipped_q.size();

   // Slab distance: exact difference scaled by 2^16, truncated, saturated.
   function automatic logic signed [63:0] slab_dist(logic signed [31:0] side,
         logic signed [31:0] org, logic signed [31:0] dir);
      logic signed [63:0] num, q;
      num = (64'(side) - 64'(org)) <<< 16;
      q = num / 64'(dir);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
   endfunction

   function automatic rsp_type clip_ray(req_type r);
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
      logic signed [63:0] t0, t1, d;
      rsp_type o;
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.direction_x, r.direction_y, r.direction_z};
      t0 = 64'(r.near_in);
      t1 = 64'(r.far_in);
      for (int a = 0; a < 3; a++) begin
         if (dir[a] == 0) continue;
         d = slab_dist(dir[a] > 0 ? box_lo[a] : box_hi[a], org[a], dir[a]);
         if (d > t0) t0 = d;
         d = slab_dist(dir[a] > 0 ? box_hi[a] : box_lo[a], org[a], dir[a]);
         if (d < t1) t1 = d;
         if (a < 2 && t0 > t1) break;
      end
      o.near_out = t0[31:0];
      o.far_out = t1[31:0];
      o.interval_empty = (t0 > t1);
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_lo[a] = '0;
            box_hi[a] = '0;
         end
         clipped_q.delete();
      end else begin
         // Register writes land at the access cycle.
         if (psel && penable && pwrite) begin
            case (paddr[ADDR_W-1:2])
               REG_MIN_X: box_lo[0] = pwdata;
               REG_MIN_Y: box_lo[1] = pwdata;
               REG_MIN_Z: box_lo[2] = pwdata;
               REG_MAX_X: box_hi[0] = pwdata;
               REG_MAX_Y: box_hi[1] = pwdata;
               REG_MAX_Z: box_hi[2] = pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) clipped_q.push_back(clip_ray(req_data));
         if (rsp_valid && rsp_ready) begin
            if (clipped_q.size() == 0) begin
               report("unexpected beat", rsp_data.near_out, 0);
            end else begin
               want = clipped_q.pop_front();
               if (rsp_data.near_out !== want.near_out)
                  report("near_out", rsp_data.near_out, want.near_out);
               if (rsp_data.far_out !== want.far_out)
                  report("far_out", rsp_data.far_out, want.far_out);
               if (rsp_data.interval_empty !== want.interval_empty)
                  report("interval_empty", 32'(rsp_data.interval_empty),
                         32'(want.interval_empty));
            end
         end
      end
   end
endmodule

@@ sim/testbench.sv @@
// Testbench top for the ray/box slab clipper: clock, reset, register writes,
// directed and random ray beats, response stalls and the verdict.
// Depends on rbsc_pkg, ray_box_slab_clip and slab_clip_checker.
module testbench;
   import rbsc_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   req_type req_data = '0;
   logic rsp_valid, req_ready, pready;
   rsp_type rsp_data;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;
   int error_count, pending;
   int hold_off = 0;
   bit stall_mode = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   ray_box_slab_clip dut (.*);
   slab_clip_checker chk (.*);

   // Receiver: random stalls, a stall-free stretch, and a long hold-off on request.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else if (stall_mode) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_W'(idx) << 2; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_ray(req_type r);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         3: return 32'($urandom_range(0, 3)) - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_dir();
      if ($urandom_range(0, 7) == 0) return 0;
      return rand_val();
   endfunction

   function automatic req_type rand_ray();
      req_type r;
      r.origin_x = rand_val(); r.origin_y = rand_val(); r.origin_z = rand_val();
      r.direction_x = rand_dir(); r.direction_y = rand_dir();
      r.direction_z = rand_dir();
      if ($urandom_range(0, 3) != 0) begin
         r.near_in = 32'h8000_0000;
         r.far_in = 32'h7fff_ffff;
      end else begin
         r.near_in = rand_val();
         r.far_in = rand_val();
      end
      return r;
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
         logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
      write_reg(REG_MIN_X, lx); write_reg(REG_MIN_Y, ly); write_reg(REG_MIN_Z, lz);
      write_reg(REG_MAX_X, hx); write_reg(REG_MAX_Y, hy); write_reg(REG_MAX_Z, hz);
   endtask

   initial begin
      req_type r;
      repeat (6) @(posedge clock);
      reset <= 0;
      set_box(32'hffff_0000, 32'hfffe_0000, 32'hffff_8000,
              32'h0001_0000, 32'h0002_0000, 32'h0000_8000);

      // Directed beats: extremes, zero directions, early exit, inverted interval.
      r = '{default: 0};
      r.near_in = 32'h8000_0000; r.far_in = 32'h7fff_ffff;
      send_ray(r);
      r.origin_x = 32'hfffb_0000; r.direction_x = 32'h0001_0000; send_ray(r);
      r.direction_x = 32'hffff_0000; send_ray(r);
      r.direction_x = 1; send_ray(r);
      r.direction_x = 32'h8000_0000; send_ray(r);
      r.origin_x = 32'h7fff_ffff; r.direction_x = 32'h7fff_ffff; send_ray(r);
      r.origin_x = 32'h8000_0000; r.direction_x = 32'hffff_ffff; send_ray(r);
      // Miss on x so y and z must be ignored.
      r = '{default: 0};
      r.origin_x = 32'h0005_0000; r.direction_x = 32'h0001_0000;
      r.origin_y = 32'h8000_0000; r.direction_y = 1;
      r.near_in = 0; r.far_in = 32'h0010_0000; send_ray(r);
      // Miss found only after y.
      r.origin_x = 0; r.origin_y = 32'h0009_0000; r.direction_y = 32'h0001_0000;
      r.direction_z = 1; send_ray(r);
      // Inverted input interval and direction on z only.
      r = '{default: 0};
      r.direction_z = 32'h0000_4000; r.near_in = 32'h0001_0000; r.far_in = 0;
      send_ray(r);
      r.direction_z = 0; send_ray(r);
      r.near_in = 32'h7fff_ffff; r.far_in = 32'h8000_0000; send_ray(r);
      r = '{default: '1}; send_ray(r);
      drain();

      // Random phases over several boxes, extremes and an inverted one among them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            1: set_box(32'h0003_0000, 32'hfffd_0000, 0, 32'hfffd_0000, 32'h0003_0000, 0);
            2: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: set_box(32'hfffc_0000, 32'hfffc_0000, 32'hfffc_0000,
                             32'h0004_0000, 32'h0004_0000, 32'h0004_0000);
         endcase
         stall_mode = (phase != 0);
         for (int n = 0; n < 220; n++) begin
            if (phase == 1 && n == 20) hold_off = 150;
            if (phase != 0 && $urandom_range(0, 9) == 0) pause_sender();
            send_ray(rand_ray());
         end
         drain();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
